// ===== src/hlps_pkg.sv =====
// Package for the length-prefix to start-code converter.
// Holds the parser phase type, the result record and the fixed constants.
// No dependencies.
package hlps_pkg;

  typedef enum logic [2:0] {
    PH_LEN0 = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_LEN3 = 3'd3,
    PH_HDR  = 3'd4,
    PH_BODY = 3'd5
  } phase_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FORBIDDEN = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;

  localparam logic [31:0] START_CODE     = 32'h0000_0001;
  localparam logic [7:0]  HDR_FORBIDDEN  = 8'h80;
  localparam logic [5:0]  NUT_SYNC_LO    = 6'd16;
  localparam logic [5:0]  NUT_SYNC_HI    = 6'd21;
  localparam logic [5:0]  NUT_DISC_MAX   = 6'd14;

  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_REPLACE = 1'b0;  // word index of replace_with_startcode

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_end;
    logic       is_sync;
    logic       is_discardable;
    logic [1:0] status;
  } res_t;

endpackage

// ===== src/hlps_front.sv =====
// Front end: accepts input bytes, tracks length-prefix framing and
// classifies NAL headers; pushes one result record per byte.
// Depends on hlps_pkg.
module hlps_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          unit_last_i,
  input  logic          replace_i,
  input  logic          full_i,
  output logic          push_o,
  output hlps_pkg::res_t res_o
);
  import hlps_pkg::*;

  phase_e      phase_q, phase_d, phase_nxt;
  logic [23:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic        sync_q, sync_d;
  logic        disc_q, disc_d;
  logic        err_q, err_d;

  logic        acc;
  logic [31:0] len_full;
  logic [5:0]  nut;
  logic [7:0]  sc_byte;
  logic        is_len;
  logic [23:0] len_u;
  logic [31:0] left_u;
  logic        sync_u, disc_u, err_u;

  assign acc        = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = acc;
  assign len_full   = {len_q, in_byte_i};
  assign nut        = in_byte_i[6:1];

  // next phase
  always_comb begin
    phase_nxt = phase_q;
    unique case (phase_q)
      PH_LEN0: phase_nxt = PH_LEN1;
      PH_LEN1: phase_nxt = PH_LEN2;
      PH_LEN2: phase_nxt = PH_LEN3;
      PH_LEN3: phase_nxt = (len_full == 32'd0) ? PH_LEN0 : PH_HDR;
      PH_HDR,
      PH_BODY: phase_nxt = (left_q == 32'd1) ? PH_LEN0 : PH_BODY;
      default: phase_nxt = PH_LEN0;
    endcase
    phase_d = phase_q;
    if (acc) begin
      phase_d = unit_last_i ? PH_LEN0 : phase_nxt;
    end
  end

  // datapath and result
  always_comb begin
    is_len  = 1'b0;
    sc_byte = in_byte_i;
    len_u   = len_q;
    left_u  = left_q;
    sync_u  = sync_q;
    disc_u  = disc_q;
    err_u   = err_q;
    unique case (phase_q)
      PH_LEN0: begin
        is_len  = 1'b1;
        sc_byte = START_CODE[31:24];
        len_u   = {len_q[15:0], in_byte_i};
      end
      PH_LEN1: begin
        is_len  = 1'b1;
        sc_byte = START_CODE[23:16];
        len_u   = {len_q[15:0], in_byte_i};
      end
      PH_LEN2: begin
        is_len  = 1'b1;
        sc_byte = START_CODE[15:8];
        len_u   = {len_q[15:0], in_byte_i};
      end
      PH_LEN3: begin
        is_len  = 1'b1;
        sc_byte = START_CODE[7:0];
        len_u   = 24'd0;
        left_u  = len_full;
      end
      PH_HDR: begin
        left_u = left_q - 32'd1;
        if (!err_q) begin
          if ((in_byte_i & HDR_FORBIDDEN) != 8'd0) begin
            err_u = 1'b1;
          end else if (nut >= NUT_SYNC_LO && nut <= NUT_SYNC_HI) begin
            sync_u = 1'b1;
          end else if (nut <= NUT_DISC_MAX && !nut[0]) begin
            disc_u = 1'b1;
          end
        end
      end
      default: begin
        left_u = left_q - 32'd1;
      end
    endcase

    res_o.out_byte       = (is_len && replace_i) ? sc_byte : in_byte_i;
    res_o.unit_end       = unit_last_i;
    res_o.is_sync        = sync_u;
    res_o.is_discardable = disc_u;
    if (err_u) begin
      res_o.status = ST_FORBIDDEN;
    end else if (unit_last_i && phase_nxt != PH_LEN0) begin
      res_o.status = ST_TRUNC;
    end else begin
      res_o.status = ST_OK;
    end

    len_d  = len_q;
    left_d = left_q;
    sync_d = sync_q;
    disc_d = disc_q;
    err_d  = err_q;
    if (acc) begin
      if (unit_last_i) begin
        len_d  = 24'd0;
        left_d = 32'd0;
        sync_d = 1'b0;
        disc_d = 1'b0;
        err_d  = 1'b0;
      end else begin
        len_d  = len_u;
        left_d = left_u;
        sync_d = sync_u;
        disc_d = disc_u;
        err_d  = err_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN0;
      len_q   <= 24'd0;
      left_q  <= 32'd0;
      sync_q  <= 1'b0;
      disc_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sync_q  <= sync_d;
      disc_q  <= disc_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== src/hlps_queue.sv =====
// Two-entry queue between front end and output stage.
// Accepts a push and a pop in the same cycle.
// Depends on hlps_pkg.
module hlps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hlps_pkg::res_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output hlps_pkg::res_t data_o
);
  import hlps_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/hlps_back.sv =====
// Output stage: registers one result record and drives the output channel.
// Pulls from the queue whenever its register is empty or being drained.
// Depends on hlps_pkg.
module hlps_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  hlps_pkg::res_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hlps_pkg::res_t out_o
);
  import hlps_pkg::*;

  res_t out_q;
  logic out_valid_q, out_valid_d;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/hevc_length_prefix_to_startcode.sv =====
// Top level: H.265 length-prefixed to start-code converter with APB config.
// Path: an accepted input byte is written into the queue (queue write), then into
// the output register, which drives the output channel.
// Throughput: unless stalled, one byte per cycle; the front parser retires one per cycle.
// Reset: parser in first-length-byte phase, queue empty, replace flag set to 1.
// Depends on hlps_pkg, hlps_front, hlps_queue, hlps_back.
module hevc_length_prefix_to_startcode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         unit_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         unit_end_o,
  output logic                         is_sync_o,
  output logic                         is_discardable_o,
  output logic [1:0]                   status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hlps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hlps_pkg::*;

  logic replace_q, replace_d;
  logic push, full, q_valid, q_pop;
  res_t front_res, q_data, out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPLACE) ? {31'd0, replace_q} : 32'd0;

  always_comb begin
    replace_d = replace_q;
    if (psel && penable && pwrite && pready && paddr[2] == REG_REPLACE) begin
      replace_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q <= 1'b1;
    end else begin
      replace_q <= replace_d;
    end
  end

  hlps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .unit_last_i (unit_last_i),
    .replace_i   (replace_q),
    .full_i      (full),
    .push_o      (push),
    .res_o       (front_res)
  );

  hlps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_res),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (full),
    .data_o  (q_data)
  );

  hlps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign out_byte_o       = out_res.out_byte;
  assign unit_end_o       = out_res.unit_end;
  assign is_sync_o        = out_res.is_sync;
  assign is_discardable_o = out_res.is_discardable;
  assign status_o         = out_res.status;

  a_trunc_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_TRUNC |-> unit_end_o)
    else $error("truncation status on a non-final byte");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FORBIDDEN || status_o == ST_TRUNC))
    else $error("undefined status code");

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register empty");

endmodule

// ===== bench/hlps_au_checker.sv =====
// Scoreboard for the length-prefix to start-code converter: follows the input and
// output channels and the APB writes, predicts each output byte and compares.
// Depends on hlps_pkg.
module hlps_au_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   in_byte_i,
  input  logic                         unit_last_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [7:0]                   out_byte_i,
  input  logic                         unit_end_i,
  input  logic                         is_sync_i,
  input  logic                         is_discardable_i,
  input  logic [1:0]                   status_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [hlps_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                  pwdata_i,
  input  logic                         pready_i,
  output int                           errors_o,
  output int                           checked_o
);
  import hlps_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_REPLACE = PADDR_W'(4 * REG_REPLACE);

  phase_e      ph;
  logic [31:0] len_acc;
  logic [31:0] remaining;
  logic        sync_hit;
  logic        disc_hit;
  logic [1:0]  err;
  logic        replace_on;

  res_t        expected_bytes[$];
  res_t        got;
  res_t        want;
  res_t        fresh;
  int          mismatches = 0;
  int          results_seen = 0;

  task automatic flag_mismatch(input string what, input logic [7:0] seen,
                               input logic [7:0] wanted);
    mismatches++;
    if (mismatches <= 60)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, seen, wanted);
  endtask

  task automatic clear_au();
    ph        = PH_LEN0;
    len_acc   = '0;
    remaining = '0;
    sync_hit  = 1'b0;
    disc_hit  = 1'b0;
    err       = ST_OK;
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic last, output res_t r);
    logic [5:0] nut;
    r.out_byte = b;
    if (ph < PH_HDR) begin
      if (replace_on)
        r.out_byte = 8'(START_CODE >> (8 * (3 - int'(ph))));
      len_acc = {len_acc[23:0], b};
      if (ph == PH_LEN3) begin
        remaining = len_acc;
        len_acc   = '0;
        ph        = (remaining == 0) ? PH_LEN0 : PH_HDR;
      end else begin
        ph = phase_e'(ph + 3'd1);
      end
    end else if (ph == PH_HDR) begin
      if (err == ST_OK) begin
        nut = b[6:1];
        if ((b & HDR_FORBIDDEN) != 0)
          err = ST_FORBIDDEN;
        else if (nut >= NUT_SYNC_LO && nut <= NUT_SYNC_HI)
          sync_hit = 1'b1;
        else if (nut <= NUT_DISC_MAX && !nut[0])
          disc_hit = 1'b1;
      end
      remaining = remaining - 1;
      ph        = (remaining == 0) ? PH_LEN0 : PH_BODY;
    end else begin
      remaining = remaining - 1;
      if (remaining == 0)
        ph = PH_LEN0;
    end
    r.unit_end       = last;
    r.is_sync        = sync_hit;
    r.is_discardable = disc_hit;
    r.status         = err;
    if (last && ph != PH_LEN0 && err == ST_OK)
      r.status = ST_TRUNC;
    if (last)
      clear_au();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_au();
      replace_on = 1'b1;
      expected_bytes.delete();
      mismatches   = 0;
      results_seen = 0;
      errors_o  <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {out_byte_i, unit_end_i, is_sync_i, is_discardable_i, status_i};
        results_seen++;
        if (expected_bytes.size() == 0) begin
          flag_mismatch("transfer with nothing pending", got.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte)
            flag_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.unit_end !== want.unit_end)
            flag_mismatch("unit_end", 8'(got.unit_end), 8'(want.unit_end));
          if (got.is_sync !== want.is_sync)
            flag_mismatch("is_sync", 8'(got.is_sync), 8'(want.is_sync));
          if (got.is_discardable !== want.is_discardable)
            flag_mismatch("is_discardable", 8'(got.is_discardable),
                          8'(want.is_discardable));
          if (got.status !== want.status)
            flag_mismatch("status", 8'(got.status), 8'(want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_parser(in_byte_i, unit_last_i, fresh);
        expected_bytes.push_back(fresh);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_REPLACE)
        replace_on = pwdata_i[0];
      errors_o  <= mismatches;
      checked_o <= results_seen;
    end
  end

endmodule

// ===== bench/hevc_length_prefix_to_startcode_tb.sv =====
// Testbench top for the length-prefix to start-code converter: clock, reset,
// access-unit stimulus with random pacing, APB writes and the verdict.
// Depends on hlps_pkg, hevc_length_prefix_to_startcode and hlps_au_checker.
module hevc_length_prefix_to_startcode_tb;
  import hlps_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [PADDR_W-1:0] ADDR_REPLACE = PADDR_W'(4 * REG_REPLACE);

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         in_byte_i;
  logic               unit_last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         out_byte_o;
  logic               unit_end_o;
  logic               is_sync_o;
  logic               is_discardable_o;
  logic [1:0]         status_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int                 errors;
  int                 checked;
  int unsigned        sent_count = 0;
  int unsigned        cycle_cnt;
  logic               calm = 1'b0;
  logic [7:0]         au_q[$];

  hevc_length_prefix_to_startcode dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .unit_last_i      (unit_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .unit_end_o       (unit_end_o),
    .is_sync_o        (is_sync_o),
    .is_discardable_o (is_discardable_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  hlps_au_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .unit_last_i      (unit_last_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_i       (out_byte_o),
    .unit_end_i       (unit_end_o),
    .is_sync_i        (is_sync_o),
    .is_discardable_i (is_discardable_o),
    .status_i         (status_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .errors_o         (errors),
    .checked_o        (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    unit_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_au();
    foreach (au_q[i])
      send_byte(au_q[i], i == au_q.size() - 1);
    au_q.delete();
  endtask

  task automatic append_nal(input logic [31:0] len, input logic [7:0] hdr);
    au_q.push_back(len[31:24]);
    au_q.push_back(len[23:16]);
    au_q.push_back(len[15:8]);
    au_q.push_back(len[7:0]);
    if (len != 0) begin
      au_q.push_back(hdr);
      for (int unsigned i = 1; i < len; i++)
        au_q.push_back(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (checked < sent_count) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_au();
    int unsigned kind, n, r, keep;
    logic [31:0] len;
    logic [5:0]  nut;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        r = $urandom_range(0, 9);
        len = (r == 0) ? 32'd0 : (r < 3) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        r = $urandom_range(0, 9);
        nut = (r < 4) ? 6'($urandom_range(16, 21)) :
              (r < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
        append_nal(len, {($urandom_range(0, 9) == 0), nut, 1'($urandom)});
      end
      // broken access unit: the tail may be cut off
      if (kind >= 76) begin
        keep = $urandom_range(1, au_q.size());
        while (au_q.size() > keep) void'(au_q.pop_back());
      end
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) au_q.push_back(8'($urandom));
    end
    send_au();
  endtask

  initial begin : sink_pacing
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("hevc_length_prefix_to_startcode_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned p;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    unit_last_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // IDR, then a zero-length unit, then a type 14 unit
    append_nal(32'd1, 8'h26);
    append_nal(32'd0, 8'h00);
    append_nal(32'd1, 8'h1C);
    send_au();
    // forbidden bit, then a cut prefix: error wins over truncation
    append_nal(32'd1, 8'hFF);
    repeat (3) au_q.push_back(8'hFF);
    send_au();
    // access unit ending inside the length prefix
    au_q.push_back(8'h00);
    send_au();
    // access unit ending after the header of a longer unit
    append_nal(32'd3, 8'h2A);
    void'(au_q.pop_back());
    void'(au_q.pop_back());
    send_au();

    target = sent_count + RANDOM_BYTES;
    p = 0;
    while (sent_count < target) begin
      wait_drained();
      cfg_write(ADDR_REPLACE, (p < 2) ? p[0] : 32'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      repeat (20) random_au();
      p++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("hevc_length_prefix_to_startcode_tb: clean");
    else
      $display("hevc_length_prefix_to_startcode_tb: errors");
    $finish;
  end

endmodule
